[rtl/swpct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swpct_pkg;

   // Field widths of the sample and result words
   localparam int SAMPLE_W  = 16;
   localparam int CHARGE_W  = 19;
   localparam int TIME_W    = 11;
   localparam int FRAC_BITS = 8;

   // Saturation limits of the result fields
   localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;
   localparam logic [TIME_W-1:0]   TIME_MAX   = '1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_CMP,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

[rtl/swpct_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sample word channel
interface swpct_req_if;
   logic                          valid;
   logic                          ready;
   logic [swpct_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Result word channel
interface swpct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swpct_pkg::CHARGE_W-1:0] peak_charge;
   logic [swpct_pkg::TIME_W-1:0]   peak_time;
   logic                          zero_charge;

   modport source (output valid, output peak_charge, output peak_time,
                   output zero_charge, input ready);
   modport sink   (input valid, input peak_charge, input peak_time,
                   input zero_charge, output ready);
endinterface

`default_nettype wire

[rtl/swpct_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module swpct_div #(
   parameter int DVD_W = 29,
   parameter int DVS_W = 19
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DVD_W-1:0]        dividend,
   input  wire logic [DVS_W-1:0]        divisor,
   output      swpct_pkg::div_stat_type stat,
   output      logic [DVD_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]    quo_ff, quo_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [DVS_W:0]      trial;
   logic                fits;

   // Shift one dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat     = swpct_pkg::div_stat_type'{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/sliding_window_peak_charge_time_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Word                                          Handshake
// req      in   sample[15:0]                                  valid/ready
// rsp      out  peak_charge[18:0] peak_time[10:0] zero_charge valid/ready
//
// A sample that closes no window leaves the sequencer idle. A sample that closes
// a window has the shared accumulator walk the window one sample a cycle, then
// pass through a compare state. The last sample of a pixel starts the bit-serial
// divider, or goes straight to the emit state with a zero best sum. Reset clears
// control and best sums only. A stalled result holds in the output register; the
// next pixel end waits on it.
module sliding_window_peak_charge_time_top #(
   parameter int SAMPLES_PER_PIXEL = 30,
   parameter int WINDOW_LENGTH     = 8
) (
   input wire logic    clock,
   input wire logic    reset,
   swpct_req_if.sink   req,
   swpct_rsp_if.source rsp
);

   localparam int SAMPLE_W = swpct_pkg::SAMPLE_W;
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int WSUM_W   = SAMPLE_W
                             + $clog2(WINDOW_LENGTH * (WINDOW_LENGTH - 1) / 2 + 1);
   localparam int DVD_W    = WSUM_W + swpct_pkg::FRAC_BITS;
   localparam int KW       = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int POS_W    = $clog2(SAMPLES_PER_PIXEL);

   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(SAMPLES_PER_PIXEL - 1);
   localparam logic [POS_W-1:0] WIN_FIRST = POS_W'(WINDOW_LENGTH - 1);
   localparam logic [POS_W-1:0] WIN_LAST  = POS_W'(SAMPLES_PER_PIXEL - 2);
   localparam logic [KW-1:0]    K_LAST    = KW'(WINDOW_LENGTH - 1);

   swpct_pkg::state_type    state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [SAMPLE_W-1:0]     win_ff [WINDOW_LENGTH];
   logic [SUM_W-1:0]        acc_sum_ff, acc_sum_in;
   logic [WSUM_W-1:0]       acc_w_ff, acc_w_in;
   logic [SUM_W-1:0]        best_sum_ff, best_sum_in;
   logic [WSUM_W-1:0]       best_w_ff, best_w_in;
   logic                    zero_ff, zero_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [swpct_pkg::CHARGE_W-1:0]  charge_ff;
   logic [swpct_pkg::TIME_W-1:0]    time_ff;
   logic                            zero_out_ff;

   logic                            req_ready;
   logic                            accept;
   logic                            out_load;
   logic                            div_start;
   logic [SAMPLE_W-1:0]             sel_sample;
   logic                            win_end;
   swpct_pkg::div_stat_type         div_stat;
   logic [DVD_W-1:0]                quotient;
   logic [swpct_pkg::CHARGE_W-1:0]  charge_sat;
   logic [swpct_pkg::TIME_W-1:0]    time_sat;

   assign accept     = req.valid && req_ready;
   assign sel_sample = win_ff[k_ff];
   assign win_end    = (pos_ff >= WIN_FIRST) && (pos_ff <= WIN_LAST);

   // Divide weighted sum by best sum for the peak time
   swpct_div #(
      .DVD_W (DVD_W),
      .DVS_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({best_w_ff, {swpct_pkg::FRAC_BITS{1'b0}}}),
      .divisor  (best_sum_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // Saturate the result fields
   always_comb begin
      if (32'(best_sum_ff) > 32'(swpct_pkg::CHARGE_MAX)) begin
         charge_sat = swpct_pkg::CHARGE_MAX;
      end else begin
         charge_sat = swpct_pkg::CHARGE_W'(best_sum_ff);
      end
      if (zero_ff) begin
         time_sat = '0;
      end else if (32'(quotient) > 32'(swpct_pkg::TIME_MAX)) begin
         time_sat = swpct_pkg::TIME_MAX;
      end else begin
         time_sat = swpct_pkg::TIME_W'(quotient);
      end
   end

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      acc_sum_in  = acc_sum_ff;
      acc_w_in    = acc_w_ff;
      best_sum_in = best_sum_ff;
      best_w_in   = best_w_ff;
      zero_in     = zero_ff;
      div_start   = 1'b0;
      req_ready   = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         swpct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (pos_ff == LAST_POS) begin
                  pos_in = '0;
                  if (best_sum_ff == '0) begin
                     zero_in  = 1'b1;
                     state_in = swpct_pkg::ST_EMIT;
                  end else begin
                     zero_in   = 1'b0;
                     div_start = 1'b1;
                     state_in  = swpct_pkg::ST_DIV;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
                  if (win_end) begin
                     k_in       = '0;
                     acc_sum_in = '0;
                     acc_w_in   = '0;
                     state_in   = swpct_pkg::ST_ACC;
                  end
               end
            end
         end
         swpct_pkg::ST_ACC: begin
            // accumulate one window sample and its offset-weighted value
            acc_sum_in = acc_sum_ff + SUM_W'(sel_sample);
            acc_w_in   = acc_w_ff + WSUM_W'(sel_sample) * WSUM_W'(k_ff);
            k_in       = k_ff + 1'b1;
            if (k_ff == K_LAST) begin
               state_in = swpct_pkg::ST_CMP;
            end
         end
         swpct_pkg::ST_CMP: begin
            // keep the first strictly greater window
            if (acc_sum_ff > best_sum_ff) begin
               best_sum_in = acc_sum_ff;
               best_w_in   = acc_w_ff;
            end
            state_in = swpct_pkg::ST_IDLE;
         end
         swpct_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = swpct_pkg::ST_EMIT;
            end
         end
         swpct_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load    = 1'b1;
               best_sum_in = '0;
               best_w_in   = '0;
               state_in    = swpct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swpct_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swpct_pkg::ST_IDLE;
         pos_ff       <= '0;
         best_sum_ff  <= '0;
         best_w_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         best_sum_ff  <= best_sum_in;
         best_w_ff    <= best_w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff       <= k_in;
      acc_sum_ff <= acc_sum_in;
      acc_w_ff   <= acc_w_in;
      zero_ff    <= zero_in;
   end

   // Advance the window line on each accepted sample
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WINDOW_LENGTH-1] <= req.sample;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         charge_ff   <= charge_sat;
         time_ff     <= time_sat;
         zero_out_ff <= zero_ff;
      end
   end

   assign req.ready       = req_ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.peak_charge = charge_ff;
   assign rsp.peak_time   = time_ff;
   assign rsp.zero_charge = zero_out_ff;

   // Zero charge word carries zero charge and zero time
   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zero_out_ff |-> charge_ff == '0 && time_ff == '0)
      else $error("zero charge word with nonzero fields");

   // Divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == swpct_pkg::ST_DIV)
      else $error("divider done outside divide state");

   // Position stays inside the pixel
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("sample position out of pixel");

   // Last sample of a pixel wraps the position to zero
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff == LAST_POS |=> pos_ff == '0)
      else $error("position did not wrap at pixel end");

endmodule

`default_nettype wire
